// ===== rtl/bsd_pkg.sv =====
// bsd_pkg: shared types and constants of the BMP stream decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package bsd_pkg;

  // Header layout (byte offsets into the 54-byte file + info header)
  localparam int unsigned HDR_LAST      = 53;
  localparam int unsigned HDR_LEN       = 54;
  localparam int unsigned HDR_KEEP      = 34;   // bytes 0..33 carry checked fields
  localparam int unsigned OFS_SIG       = 0;
  localparam int unsigned OFS_DATA_OFS  = 10;
  localparam int unsigned OFS_INFO_SIZE = 14;
  localparam int unsigned OFS_WIDTH     = 18;
  localparam int unsigned OFS_HEIGHT    = 22;
  localparam int unsigned OFS_PLANES    = 26;
  localparam int unsigned OFS_BPP       = 28;
  localparam int unsigned OFS_COMPRESS  = 30;
  localparam int unsigned IDX_GEOM_A    = 40;   // first derived-geometry step
  localparam int unsigned IDX_GEOM_B    = 41;   // second derived-geometry step

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [31:0] INFO_HDR_SIZE = 32'd40;
  localparam logic [15:0] BPP_24        = 16'd24;
  localparam logic [15:0] BPP_32        = 16'd32;
  localparam logic [15:0] ONE_PLANE     = 16'd1;

  // Parse phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_PIXEL  = 3'd2;
  localparam logic [2:0] PH_DONE   = 3'd3;
  localparam logic [2:0] PH_ERROR  = 3'd4;

  typedef logic [1:0] err_code_t;
  localparam err_code_t ERR_NONE        = 2'd0;
  localparam err_code_t ERR_CORRUPTED   = 2'd1;
  localparam err_code_t ERR_INVALID     = 2'd2;
  localparam err_code_t ERR_UNSUPPORTED = 2'd3;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // Decoded orientation and pixel size
  typedef struct packed {
    logic bpp4;        // 32 bits per pixel
    logic bottom_up;   // positive height, rows stored bottom first
  } hdr_flags_t;

  // One result beat
  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       has_alpha;
    logic [11:0] column;
    logic [11:0] out_row;
    logic       last_pixel;
    err_code_t  error_code;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/bsd_hdr.sv =====
// bsd_hdr: captures the BMP headers, checks them and derives the image geometry.
// Depends on bsd_pkg.
`default_nettype none

module bsd_hdr #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned DW = $clog2(4 * MAX_WIDTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,      // header byte accepted
  input  wire logic [5:0]            idx,        // byte index within the header
  input  wire logic [7:0]            byte_in,
  output bsd_pkg::err_code_t         chk_code,   // valid when idx is the last header byte
  output bsd_pkg::hdr_flags_t        flags,
  output logic [31:0]                data_ofs,
  output logic [CW-1:0]              img_w,
  output logic [CW-1:0]              img_wm1,
  output logic [RW-1:0]              img_hm1,
  output logic [DW-1:0]              row_last
);
  import bsd_pkg::*;

  logic [7:0]    hb_r [0:HDR_KEEP-1];
  logic [31:0]   hmag_r;
  logic          bpp4_r;
  logic          bottom_up_r;
  logic [DW-1:0] data_len_r;
  logic [DW-1:0] row_last_r;
  logic [CW-1:0] wm1_r;
  logic [RW-1:0] hm1_r;

  logic [15:0] sig, planes, bpp;
  logic [31:0] info_size, width, height, compress;
  logic [DW-1:0] wc;

  assign sig       = {hb_r[OFS_SIG+1], hb_r[OFS_SIG]};
  assign data_ofs  = {hb_r[OFS_DATA_OFS+3], hb_r[OFS_DATA_OFS+2],
                      hb_r[OFS_DATA_OFS+1], hb_r[OFS_DATA_OFS]};
  assign info_size = {hb_r[OFS_INFO_SIZE+3], hb_r[OFS_INFO_SIZE+2],
                      hb_r[OFS_INFO_SIZE+1], hb_r[OFS_INFO_SIZE]};
  assign width     = {hb_r[OFS_WIDTH+3], hb_r[OFS_WIDTH+2],
                      hb_r[OFS_WIDTH+1], hb_r[OFS_WIDTH]};
  assign height    = {hb_r[OFS_HEIGHT+3], hb_r[OFS_HEIGHT+2],
                      hb_r[OFS_HEIGHT+1], hb_r[OFS_HEIGHT]};
  assign planes    = {hb_r[OFS_PLANES+1], hb_r[OFS_PLANES]};
  assign bpp       = {hb_r[OFS_BPP+1], hb_r[OFS_BPP]};
  assign compress  = {hb_r[OFS_COMPRESS+3], hb_r[OFS_COMPRESS+2],
                      hb_r[OFS_COMPRESS+1], hb_r[OFS_COMPRESS]};

  assign wc = DW'(width[CW-1:0]);

  always_ff @(posedge clk) begin
    if (wr_en && (32'(idx) < HDR_KEEP)) begin
      hb_r[idx] <= byte_in;
    end
    // all checked fields are complete by now; derive geometry in two steps
    if (wr_en && (32'(idx) == IDX_GEOM_A)) begin
      hmag_r      <= height[31] ? (32'd0 - height) : height;
      bottom_up_r <= ~height[31];
      bpp4_r      <= (bpp == BPP_32);
      wm1_r       <= width[CW-1:0] - CW'(1);
      data_len_r  <= (bpp == BPP_32) ? (wc << 2) : (wc + (wc << 1));
    end
    if (wr_en && (32'(idx) == IDX_GEOM_B)) begin
      hm1_r      <= hmag_r[RW-1:0] - RW'(1);
      // last byte index of a row padded to a multiple of four
      row_last_r <= (data_len_r - DW'(1)) | DW'(3);
    end
  end

  always_comb begin
    chk_code = ERR_NONE;
    priority if (sig != BMP_SIGNATURE)              chk_code = ERR_INVALID;
    else if (info_size != INFO_HDR_SIZE)            chk_code = ERR_INVALID;
    else if ((width == 32'd0) || width[31])         chk_code = ERR_INVALID;
    else if (height == 32'd0)                       chk_code = ERR_INVALID;
    else if (planes != ONE_PLANE)                   chk_code = ERR_INVALID;
    else if (data_ofs < HDR_LEN)                    chk_code = ERR_INVALID;
    else if ((bpp != BPP_24) && (bpp != BPP_32))    chk_code = ERR_UNSUPPORTED;
    else if (compress != 32'd0)                     chk_code = ERR_UNSUPPORTED;
    else if ((width > 32'(MAX_WIDTH)) || (hmag_r > 32'(MAX_HEIGHT)))
                                                    chk_code = ERR_UNSUPPORTED;
    else                                            chk_code = ERR_NONE;
  end

  assign flags.bpp4      = bpp4_r;
  assign flags.bottom_up = bottom_up_r;
  assign img_w           = width[CW-1:0];
  assign img_wm1         = wm1_r;
  assign img_hm1         = hm1_r;
  assign row_last        = row_last_r;

endmodule

`default_nettype wire

// ===== rtl/bsd_pix.sv =====
// bsd_pix: walks pixel data bytes, drops row padding and forms pixel results.
// Depends on bsd_pkg.
`default_nettype none

module bsd_pix #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned DW = $clog2(4 * MAX_WIDTH + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,     // header accepted: rewind counters
  input  wire logic                step,      // one pixel-area byte accepted
  input  wire logic [7:0]          byte_in,
  input  bsd_pkg::hdr_flags_t      flags,
  input  wire logic [CW-1:0]       img_w,
  input  wire logic [CW-1:0]       img_wm1,
  input  wire logic [RW-1:0]       img_hm1,
  input  wire logic [DW-1:0]       row_last,
  output logic                     emit,
  output logic                     done,
  output bsd_pkg::res_t            res
);
  import bsd_pkg::*;

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [DW-1:0] rbc_r;
  logic [1:0]    ch_r;
  logic [7:0]    pb_r [0:2];

  logic          in_data;
  logic          px_end;
  logic          last;
  logic [RW-1:0] dst_row;

  assign in_data = (col_r < img_w);
  assign px_end  = (ch_r == (flags.bpp4 ? 2'd3 : 2'd2));
  assign last    = (col_r == img_wm1) && (row_r == img_hm1);
  assign emit    = step && in_data && px_end;
  assign done    = emit && last;
  assign dst_row = flags.bottom_up ? (img_hm1 - row_r) : row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      rbc_r <= '0;
      ch_r  <= '0;
    end else if (start) begin
      col_r <= '0;
      row_r <= '0;
      rbc_r <= '0;
      ch_r  <= '0;
    end else if (step) begin
      if (in_data) begin
        if (px_end) begin
          col_r <= col_r + CW'(1);
          ch_r  <= '0;
        end else begin
          ch_r <= ch_r + 2'd1;
        end
      end
      // row end wins over the column advance above
      if (rbc_r == row_last) begin
        rbc_r <= '0;
        col_r <= '0;
        ch_r  <= '0;
        row_r <= row_r + RW'(1);
      end else begin
        rbc_r <= rbc_r + DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_data && (ch_r != 2'd3)) begin
      pb_r[ch_r] <= byte_in;
    end
  end

  always_comb begin
    res            = '0;
    res.kind       = KIND_PIXEL;
    res.red        = flags.bpp4 ? pb_r[2] : byte_in;
    res.green      = pb_r[1];
    res.blue       = pb_r[0];
    res.alpha      = flags.bpp4 ? byte_in : 8'hFF;
    res.has_alpha  = flags.bpp4;
    res.column     = 12'(col_r);
    res.out_row    = 12'(dst_row);
    res.last_pixel = last;
    res.error_code = ERR_NONE;
  end

endmodule

`default_nettype wire

// ===== rtl/bsd_obuf.sv =====
// bsd_obuf: two-entry result buffer (output register plus skid entry).
// Depends on bsd_pkg.
`default_nettype none

module bsd_obuf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  bsd_pkg::res_t      din,
  output logic               full,
  output logic               out_valid,
  input  wire logic          out_stall,
  output bsd_pkg::res_t      dout
);
  import bsd_pkg::*;

  logic v0_r, v1_r;
  res_t d0_r, d1_r;
  logic pop;

  assign pop = v0_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (!v0_r || pop) begin
      if (v1_r) begin
        v0_r <= 1'b1;
        v1_r <= 1'b0;
      end else begin
        v0_r <= push;
      end
    end else if (push) begin
      v1_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!v0_r || pop) begin
      if (v1_r) begin
        d0_r <= d1_r;
      end else if (push) begin
        d0_r <= din;
      end
    end else if (push) begin
      d1_r <= din;
    end
  end

  assign full      = v1_r;
  assign out_valid = v0_r;
  assign dout      = d0_r;

endmodule

`default_nettype wire

// ===== rtl/bmp_stream_decoder_core.sv =====
// bmp_stream_decoder_core: top level of the streaming BMP decoder.
// Depends on bsd_pkg, bsd_hdr, bsd_pix and bsd_obuf.
//
// Usage:
//   Feed the BMP file one byte per input beat (in_file_byte), with
//   in_end_of_file high on the final byte. The block checks the 54-byte
//   header, skips to the data offset and returns one result beat per
//   decoded pixel (RGB(A), column, destination row, last_pixel), or one
//   error beat (out_kind high, out_error_code) for a bad header or a file
//   that ends early. Bytes after the final pixel produce nothing.
//   Throughput: one byte per cycle while in_stall is low. Each byte needs only counter
//   updates and compares against geometry registered during the header.
//   Results: each result is registered into the result buffer and shows on
//   out_* once no earlier result is still waiting ahead of it.
//   Stall: results go into a two-entry buffer; in_stall rises only when
//   both entries are held, so a byte is still taken while one finished
//   result waits. Stalled results hold their payload.
//   Reset (rst_n low, synchronous) and every end-of-file byte return the
//   parser to the header phase; reset also empties the result buffer.
//   No clearing pass: the block takes bytes the cycle after reset.
`default_nettype none

module bmp_stream_decoder_core #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // byte input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_file_byte,
  input  wire logic                 in_end_of_file,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_kind,
  output logic [7:0]                out_red,
  output logic [7:0]                out_green,
  output logic [7:0]                out_blue,
  output logic [7:0]                out_alpha,
  output logic                      out_has_alpha,
  output logic [11:0]               out_column,
  output logic [11:0]               out_out_row,
  output logic                      out_last_pixel,
  output bsd_pkg::err_code_t        out_error_code
);
  import bsd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DW = $clog2(4 * MAX_WIDTH + 1);

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] pos_r;       // index of the next file byte, wraps at 32 bits

  logic        in_acc;
  logic        hdr_wr, hdr_last;
  logic        pix_start, pix_step;
  logic        hdr_err, eof_err;
  logic        buf_full;

  err_code_t   chk_code;
  hdr_flags_t  flags;
  logic [31:0] data_ofs;
  logic [CW-1:0] img_w, img_wm1;
  logic [RW-1:0] img_hm1;
  logic [DW-1:0] row_last;

  logic        pix_emit, pix_done;
  res_t        pix_res, res_in, res_out;
  logic        push;

  assign in_stall = buf_full;
  assign in_acc   = in_valid && !in_stall;
  assign hdr_wr   = in_acc && (phase_r == PH_HEADER);
  assign hdr_last = (pos_r == 32'(HDR_LAST));

  bsd_hdr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_hdr (
    .clk      (clk),
    .wr_en    (hdr_wr),
    .idx      (pos_r[5:0]),
    .byte_in  (in_file_byte),
    .chk_code (chk_code),
    .flags    (flags),
    .data_ofs (data_ofs),
    .img_w    (img_w),
    .img_wm1  (img_wm1),
    .img_hm1  (img_hm1),
    .row_last (row_last)
  );

  // Phase sequencing for the accepted byte
  always_comb begin
    phase_nxt = phase_r;
    pix_start = 1'b0;
    pix_step  = 1'b0;
    hdr_err   = 1'b0;
    if (in_acc) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hdr_last) begin
            if (chk_code != ERR_NONE) begin
              hdr_err   = 1'b1;
              phase_nxt = PH_ERROR;
            end else begin
              pix_start = 1'b1;
              phase_nxt = (data_ofs == 32'(HDR_LEN)) ? PH_PIXEL : PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          // reaching the data offset: this byte is already pixel data
          if (pos_r == data_ofs) begin
            phase_nxt = PH_PIXEL;
            pix_step  = 1'b1;
          end
        end
        PH_PIXEL: begin
          pix_step = 1'b1;
        end
        default: begin
          // done or error: drop the byte
        end
      endcase
      if (pix_done) begin
        phase_nxt = PH_DONE;
      end
    end
  end

  // End of file before the image is complete is a short file
  assign eof_err = in_acc && in_end_of_file &&
                   ((phase_nxt == PH_HEADER) || (phase_nxt == PH_SKIP) ||
                    (phase_nxt == PH_PIXEL));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
    end else if (in_acc) begin
      if (in_end_of_file) begin
        // re-arm for the next file
        phase_r <= PH_HEADER;
        pos_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        pos_r   <= pos_r + 32'd1;
      end
    end
  end

  bsd_pix #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pix (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (pix_start),
    .step     (pix_step),
    .byte_in  (in_file_byte),
    .flags    (flags),
    .img_w    (img_w),
    .img_wm1  (img_wm1),
    .img_hm1  (img_hm1),
    .row_last (row_last),
    .emit     (pix_emit),
    .done     (pix_done),
    .res      (pix_res)
  );

  // Result select: short-file error beats a pixel, header error beats both
  always_comb begin
    res_in = pix_res;
    if (hdr_err) begin
      res_in            = '0;
      res_in.kind       = KIND_ERROR;
      res_in.error_code = chk_code;
    end else if (eof_err) begin
      res_in            = '0;
      res_in.kind       = KIND_ERROR;
      res_in.error_code = ERR_CORRUPTED;
    end
  end

  assign push = hdr_err || eof_err || pix_emit;

  bsd_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (res_in),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (res_out)
  );

  assign out_kind       = res_out.kind;
  assign out_red        = res_out.red;
  assign out_green      = res_out.green;
  assign out_blue       = res_out.blue;
  assign out_alpha      = res_out.alpha;
  assign out_has_alpha  = res_out.has_alpha;
  assign out_column     = res_out.column;
  assign out_out_row    = res_out.out_row;
  assign out_last_pixel = res_out.last_pixel;
  assign out_error_code = res_out.error_code;

endmodule

`default_nettype wire

// ===== rtl/bsd_chk.sv =====
// bsd_chk: port-level assertions for bmp_stream_decoder_core, bound to the top.
// Depends on bsd_pkg.
`default_nettype none

module bsd_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [7:0]         in_file_byte,
  input wire logic               in_end_of_file,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               out_kind,
  input wire logic [7:0]         out_red,
  input wire logic [7:0]         out_green,
  input wire logic [7:0]         out_blue,
  input wire logic [7:0]         out_alpha,
  input wire logic               out_has_alpha,
  input wire logic [11:0]        out_column,
  input wire logic [11:0]        out_out_row,
  input wire logic               out_last_pixel,
  input bsd_pkg::err_code_t      out_error_code
);
  import bsd_pkg::*;

  // Hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_red) && $stable(out_column) && $stable(out_out_row) &&
      $stable(out_error_code))
    else $error("stalled result beat changed");

  // Error beats carry a code and no pixel data in red, alpha, column or last_pixel
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ERROR) |->
      (out_error_code != ERR_NONE) && (out_red == 8'd0) && (out_alpha == 8'd0) &&
      !out_has_alpha && (out_column == 12'd0) && !out_last_pixel)
    else $error("error beat carries pixel data");

  // Pixel beats carry no error code; opaque alpha without an alpha channel
  a_pix_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_PIXEL) |->
      (out_error_code == ERR_NONE) && (out_has_alpha || (out_alpha == 8'hFF)))
    else $error("malformed pixel beat");

  // Input backpressure only follows a stalled result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("in_stall raised without output stall");

endmodule

bind bmp_stream_decoder_core bsd_chk u_bsd_chk (.*);

`default_nettype wire
